// ----- sv/sha1hs_pkg.sv -----
// Shared types, constants and helpers for the byte-serial SHA-1 engine.
package sha1hs_pkg;

  // Default depth of the word queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Sequencer end points
  localparam logic [6:0] LoadLast  = 7'd15;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [2:0] LastIdx   = 3'd4;

  // Padding marker byte
  localparam logic [7:0] PadByte = 8'h80;

  // Initial chaining vector
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // One big-endian message word on its way to the compression engine
  typedef struct packed {
    logic [31:0] word;
    logic        last_blk;
  } q_entry_t;

  typedef enum logic {
    FS_ABSORB,
    FS_PAD
  } front_state_t;

  typedef enum logic [1:0] {
    BS_LOAD,
    BS_ROUND,
    BS_ADD,
    BS_EMIT
  } back_state_t;

  // Place a byte in its big-endian lane of a 32-bit word
  function automatic logic [31:0] lane_word(input logic [7:0] b, input logic [1:0] lane);
    logic [31:0] w;
    begin
      case (lane)
        2'd0:    w = {b, 24'h000000};
        2'd1:    w = {8'h00, b, 16'h0000};
        2'd2:    w = {16'h0000, b, 8'h00};
        default: w = {24'h000000, b};
      endcase
      return w;
    end
  endfunction

endpackage

// ----- sv/sha1hs_queue.sv -----
// Word queue with a registered head entry between the front and back parts.
module sha1hs_queue
  import sha1hs_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t din,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     head_valid
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  q_entry_t        mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            wr_ok;
  logic            fill;

  assign full  = (count == CntFull);
  assign wr_ok = push && !full;
  assign fill  = (!head_valid || pop) && (count != '0);

  // Write storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= din;
    end
  end

  // Refill head register
  always_ff @(posedge clk) begin
    if (fill) begin
      head <= mem[rd_ptr];
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (fill) begin
        rd_ptr     <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
      case ({wr_ok, fill})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/sha1hs_front.sv -----
// Front part: packs message bytes into words, counts them, and generates padding.
module sha1hs_front
  import sha1hs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       end_of_message,
  output logic       q_push,
  output q_entry_t   q_entry,
  input  logic       q_full
);

  front_state_t state;
  front_state_t state_next;
  logic [63:0]  byte_count;
  logic [31:0]  acc;
  logic [3:0]   widx;
  logic         first_word;
  logic         second_blk;

  logic [5:0]   pos;
  logic [1:0]   lane;
  logic [5:0]   pos_after;
  logic [31:0]  acc_eff;
  logic [31:0]  acc_new;
  logic [63:0]  bit_len;
  logic         take;
  logic         need_extra;
  logic         len_ok;
  logic [31:0]  pad_word;

  // Decode byte position and build candidate words
  always_comb begin
    pos        = byte_count[5:0];
    lane       = pos[1:0];
    pos_after  = pos + 6'(byte_present);
    acc_eff    = (lane == 2'd0) ? 32'h0 : acc;
    acc_new    = acc_eff | lane_word(data_byte, lane);
    take       = in_valid && in_ready;
    need_extra = (pos[5:3] == 3'd7);
    len_ok     = !need_extra || second_blk;
    bit_len    = {byte_count[60:0], 3'b000};
    if (first_word) begin
      pad_word = acc_eff | lane_word(PadByte, lane);
    end else if (len_ok && (widx == 4'd14)) begin
      pad_word = bit_len[63:32];
    end else if (len_ok && (widx == 4'd15)) begin
      pad_word = bit_len[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_ABSORB: begin
        if (take && end_of_message) begin
          state_next = FS_PAD;
        end
      end
      FS_PAD: begin
        if (q_push && (widx == 4'd15) && len_ok) begin
          state_next = FS_ABSORB;
        end
      end
      default: state_next = FS_ABSORB;
    endcase
  end

  // Handshake and queue outputs
  always_comb begin
    in_ready = 1'b0;
    q_push   = 1'b0;
    q_entry  = '{word: acc_new, last_blk: 1'b0};
    unique case (state)
      FS_ABSORB: begin
        in_ready = !q_full;
        q_push   = take && byte_present && (lane == 2'd3);
      end
      FS_PAD: begin
        q_push  = !q_full;
        q_entry = '{word: pad_word, last_blk: (widx == 4'd15) && len_ok};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold partial word
  always_ff @(posedge clk) begin
    if ((state == FS_ABSORB) && take && byte_present) begin
      acc <= acc_new;
    end
  end

  // Advance counters and pad sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FS_ABSORB;
      byte_count <= '0;
      widx       <= '0;
      first_word <= 1'b0;
      second_blk <= 1'b0;
    end else begin
      state <= state_next;
      if (state == FS_ABSORB) begin
        if (take && byte_present) begin
          byte_count <= byte_count + 64'd1;
        end
        if (take && end_of_message) begin
          widx       <= pos_after[5:2];
          first_word <= 1'b1;
          second_blk <= 1'b0;
        end
      end else if (q_push) begin
        first_word <= 1'b0;
        widx       <= widx + 4'd1;
        if (widx == 4'd15) begin
          if (len_ok) begin
            byte_count <= '0;
          end else begin
            second_blk <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- sv/sha1hs_back.sv -----
// Back part: loads a block of words, runs the 80 rounds, and emits the digest.
module sha1hs_back
  import sha1hs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  logic        head_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  back_state_t state;
  back_state_t state_next;
  logic [6:0]  rnd;
  logic [2:0]  emit_idx;
  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] sw [16];
  logic        last_blk;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic        out_load;
  logic        load_done;

  // Round function, constant and schedule expansion
  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp   = {a[26:0], a[31:27]} + f + e + k + sw[0];
    w_mix = sw[13] ^ sw[8] ^ sw[2] ^ sw[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_LOAD:  if (load_done) state_next = BS_ROUND;
      BS_ROUND: if (rnd == RoundLast) state_next = BS_ADD;
      BS_ADD:   state_next = last_blk ? BS_EMIT : BS_LOAD;
      BS_EMIT:  if (out_load && (emit_idx == LastIdx)) state_next = BS_LOAD;
      default:  state_next = BS_LOAD;
    endcase
  end

  // Queue pop and output load strobes
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BS_LOAD: pop      = head_valid;
      BS_EMIT: out_load = !out_valid || out_ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign load_done = pop && (rnd == LoadLast);

  // Shift schedule window
  always_ff @(posedge clk) begin
    if (pop || (state == BS_ROUND)) begin
      for (int i = 0; i < 15; i++) begin
        sw[i] <= sw[i+1];
      end
      sw[15] <= pop ? head.word : w_new;
    end
  end

  // Working variables and block tag
  always_ff @(posedge clk) begin
    if (load_done) begin
      a        <= chain[0];
      b        <= chain[1];
      c        <= chain[2];
      d        <= chain[3];
      e        <= chain[4];
      last_blk <= head.last_blk;
    end else if (state == BS_ROUND) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  // Digest output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word <= chain[emit_idx];
      word_index  <= emit_idx;
      last_word   <= (emit_idx == LastIdx);
    end
  end

  // Sequencer, chaining words and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_LOAD;
      rnd       <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      chain[0]  <= Iv0;
      chain[1]  <= Iv1;
      chain[2]  <= Iv2;
      chain[3]  <= Iv3;
      chain[4]  <= Iv4;
    end else begin
      state <= state_next;
      if (pop) begin
        rnd <= (rnd == LoadLast) ? '0 : rnd + 7'd1;
      end else if (state == BS_ROUND) begin
        rnd <= (rnd == RoundLast) ? '0 : rnd + 7'd1;
      end
      if (state == BS_ADD) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        emit_idx  <= (emit_idx == LastIdx) ? '0 : emit_idx + 3'd1;
        if (emit_idx == LastIdx) begin
          chain[0] <= Iv0;
          chain[1] <= Iv1;
          chain[2] <= Iv2;
          chain[3] <= Iv3;
          chain[4] <= Iv4;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/sha1_hash_stream.sv -----
// Top level of the byte-serial SHA-1 engine: front, word queue and back.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_ready  | data_byte, byte_present, end_of_message
//   output  | out_valid / out_ready| digest_word, word_index, last_word
//
// The front takes one transaction per cycle while the word queue has room and no
// padding is being pushed. For each block the back loads 16 words, runs 80 rounds
// and does one chaining add. The queue and its head hold only five words, so most
// words of a streamed block arrive during the load, paced by the front's byte packing.
// Finishing holds off input while the front pushes one or two padded blocks into
// the queue; five digest transactions follow, one per cycle when out_ready is high.
// Reset is synchronous; no memory needs clearing.
// Input stalls while the queue is full or padding is pushed; output stalls
// backpressure the back.
module sha1_hash_stream
  import sha1hs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic     q_push;
  logic     q_full;
  q_entry_t q_in;
  q_entry_t q_head;
  logic     q_head_valid;
  logic     q_pop;

  sha1hs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .q_push         (q_push),
    .q_entry        (q_in),
    .q_full         (q_full)
  );

  sha1hs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .din        (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  sha1hs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_valid  (q_head_valid),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // Front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("word pushed into full queue");

  // Back never pops an empty head
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_head_valid)
    else $error("pop from empty queue head");

  // Last flag marks exactly the fifth digest word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == LastIdx)))
    else $error("last_word does not match word_index");

  // Digest words follow one another without gaps
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && (word_index == $past(word_index) + 3'd1)))
    else $error("digest word sequence broken");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the byte-serial SHA-1 stream engine.
module tb_top;

  // Slow-run bound: stalls on both sides plus one or two padded blocks per message
  localparam int CycleLimit = 400000;
  // Cycles to hold after the last digest so stray transactions still get caught
  localparam int TailCycles = 300;
  // Rough number of byte and end transactions for the whole run
  localparam int ItemBudget = 120;

  // SHA-1 initial chaining vector and round constants
  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;
  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;
  localparam logic [7:0]  PadMarker = 8'h80;
  localparam logic [2:0]  LastWordIdx = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_flag;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Digest model state
  logic [31:0] chain [0:4];
  logic [7:0]  blk_bytes [0:63];
  logic [63:0] msg_len;

  digest_beat_t pending_digest_words [$];
  int fail_count = 0;
  int items_sent = 0;
  int messages_done = 0;
  int cycle_count = 0;
  bit gaps_enabled = 1'b1;
  bit stall_enabled = 1'b1;
  int stall_left = 0;

  sha1_hash_stream dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle span: mostly short, now and then long
  function automatic int pick_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic sha_load_iv();
    chain[0] = InitH0;
    chain[1] = InitH1;
    chain[2] = InitH2;
    chain[3] = InitH3;
    chain[4] = InitH4;
    msg_len = 64'd0;
  endtask

  // Run 80 rounds over the current block and fold into the chain
  task automatic sha_compress_block();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = rotl32(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endtask

  // Pad, compress the tail, queue the five digest words, restart
  task automatic sha_finish_message();
    logic [63:0] bit_len;
    int pos;
    digest_beat_t beat;
    bit_len = msg_len << 3;
    pos = int'(msg_len[5:0]);
    blk_bytes[pos] = PadMarker;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) blk_bytes[i] = 8'h00;
      sha_compress_block();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) blk_bytes[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
    sha_compress_block();
    for (int i = 0; i < 5; i++) begin
      beat.word = chain[i];
      beat.index = 3'(i);
      beat.last_flag = (3'(i) == LastWordIdx);
      pending_digest_words.push_back(beat);
    end
    sha_load_iv();
  endtask

  // Advance the model by one accepted transaction
  task automatic sha_absorb_item(input logic [7:0] b, input logic present, input logic eom);
    if (present) begin
      blk_bytes[msg_len[5:0]] = b;
      msg_len++;
      if (msg_len[5:0] == 6'd0) sha_compress_block();
    end
    if (eom) sha_finish_message();
  endtask

  // Drive one input transaction and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    int gap;
    gap = (gaps_enabled && $urandom_range(0, 99) < 35) ? pick_span() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sha_absorb_item(b, present, eom);
    if (present || eom) items_sent++;
  endtask

  // Drop valid and hold until every queued digest word has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digest_words.size() != 0) @(posedge clk);
  endtask

  // One message of random bytes; optional idle transactions sprinkled in
  task automatic send_message(input int len, input bit end_on_byte, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!(end_on_byte && len > 0))
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_done++;
  endtask

  task automatic test_empty_message();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_short_messages();
    // End rides on the last byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Separate end, with idle transactions mid-message
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Full-rate traffic: a message whose padding spills into a second block,
  // then an empty one, no idling on either side
  task automatic test_back_to_back();
    gaps_enabled = 1'b0;
    stall_enabled = 1'b0;
    send_message(57, 1'b0, 1'b0);
    send_message(0, 1'b0, 1'b0);
    wait_drain();
    gaps_enabled = 1'b1;
    stall_enabled = 1'b1;
  endtask

  task automatic test_random_messages();
    int len;
    int r;
    while (items_sent < ItemBudget || messages_done < 8) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      stall_enabled = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 12);
      else len = $urandom_range(13, 40);
      // Keep the run near its transaction budget
      if (len > ItemBudget - items_sent - 1) len = ItemBudget - items_sent - 1;
      if (len < 0) len = 0;
      send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) wait_drain();
    end
    gaps_enabled = 1'b1;
    stall_enabled = 1'b1;
  endtask

  // Check each digest transaction and drive out_ready with random stalls
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_digest_words.size() == 0) begin
        $display("%0t unexpected digest transaction: word %h index %0d last %b",
                 $time, digest_word, word_index, last_word);
        fail_count++;
      end else begin
        want = pending_digest_words.pop_front();
        if (digest_word !== want.word) begin
          $display("%0t digest_word mismatch: expected %h actual %h",
                   $time, want.word, digest_word);
          fail_count++;
        end
        if (word_index !== want.index) begin
          $display("%0t word_index mismatch: expected %0d actual %0d",
                   $time, want.index, word_index);
          fail_count++;
        end
        if (last_word !== want.last_flag) begin
          $display("%0t last_word mismatch: expected %b actual %b",
                   $time, want.last_flag, last_word);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_enabled && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_span() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sha_load_iv();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_short_messages();
    test_byte_extremes();
    test_back_to_back();
    test_random_messages();
    wait_drain();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
